>>> rtl/core/audio_pll_sample_rate_decode_core_assert.svh
// assertion macros shared by the sample rate decoder modules
// expects clk and rst in the scope of each use
`ifndef AUDIO_PLL_SAMPLE_RATE_DECODE_CORE_ASSERT_SVH
`define AUDIO_PLL_SAMPLE_RATE_DECODE_CORE_ASSERT_SVH

// same-cycle implication
`define APSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apsr assertion failed");

// next-cycle implication
`define APSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apsr assertion failed");

`endif

>>> rtl/core/apsr_pkg.sv
// types, constants and lookup functions of the sample rate decoder
// no dependencies
package apsr_pkg;

  localparam int unsigned DivW   = 38;
  localparam int unsigned RemW   = 15;
  localparam int unsigned RawW   = 30;
  localparam int unsigned RateW  = 17;
  localparam int unsigned CntW   = 6;
  localparam int unsigned IdxW   = 4;

  localparam logic [CntW-1:0] DivSteps = 6'd38;
  localparam logic [CntW-1:0] NumStd   = 6'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV1,
    ST_SET2,
    ST_DIV2,
    ST_SET3,
    ST_DIV3,
    ST_SNAP_INIT,
    ST_SNAP,
    ST_PUB
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL,
    DP_DIV_STEP,
    DP_SET2,
    DP_SET3,
    DP_SNAP_INIT,
    DP_SNAP_STEP,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [IdxW-1:0] snap_idx;
  } cmd_t;

  function automatic logic [24:0] ref_freq(input logic [1:0] sel);
    logic [24:0] f;
    unique case (sel)
      2'd0:    f = 25'd13000000;
      2'd1:    f = 25'd19200000;
      2'd2:    f = 25'd12000000;
      default: f = 25'd26000000;
    endcase
    return f;
  endfunction

  function automatic logic [RateW-1:0] std_rate(input logic [IdxW-1:0] idx);
    logic [RateW-1:0] r;
    unique case (idx)
      4'd0:    r = 17'd8000;
      4'd1:    r = 17'd11025;
      4'd2:    r = 17'd16000;
      4'd3:    r = 17'd22050;
      4'd4:    r = 17'd24000;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd44100;
      4'd7:    r = 17'd48000;
      4'd8:    r = 17'd88200;
      4'd9:    r = 17'd96000;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/apsr_ctrl.sv
// sequencer of the sample rate decoder: handshakes, step counting, commands
// depends on apsr_pkg and the assertion macro header
`include "audio_pll_sample_rate_decode_core_assert.svh"

module apsr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output apsr_pkg::cmd_t cmd
);

  apsr_pkg::state_t state;
  apsr_pkg::state_t state_next;
  logic [apsr_pkg::CntW-1:0] cnt;
  logic div_last;
  logic snap_last;
  logic can_pub;

  assign div_last  = (cnt == apsr_pkg::DivSteps - 6'd1);
  assign snap_last = (cnt == apsr_pkg::NumStd - 6'd1);
  assign can_pub   = !out_valid || !out_stall;
  assign in_stall  = (state != apsr_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      apsr_pkg::ST_IDLE:      if (in_valid) state_next = apsr_pkg::ST_MUL;
      apsr_pkg::ST_MUL:       state_next = apsr_pkg::ST_DIV1;
      apsr_pkg::ST_DIV1:      if (div_last) state_next = apsr_pkg::ST_SET2;
      apsr_pkg::ST_SET2:      state_next = apsr_pkg::ST_DIV2;
      apsr_pkg::ST_DIV2:      if (div_last) state_next = apsr_pkg::ST_SET3;
      apsr_pkg::ST_SET3:      state_next = apsr_pkg::ST_DIV3;
      apsr_pkg::ST_DIV3:      if (div_last) state_next = apsr_pkg::ST_SNAP_INIT;
      apsr_pkg::ST_SNAP_INIT: state_next = apsr_pkg::ST_SNAP;
      apsr_pkg::ST_SNAP:      if (snap_last) state_next = apsr_pkg::ST_PUB;
      apsr_pkg::ST_PUB:       if (can_pub) state_next = apsr_pkg::ST_IDLE;
      default:                state_next = apsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = apsr_pkg::DP_NOP;
    cmd.snap_idx = cnt[apsr_pkg::IdxW-1:0];
    unique case (state)
      apsr_pkg::ST_IDLE:      if (in_valid) cmd.op = apsr_pkg::DP_LOAD;
      apsr_pkg::ST_MUL:       cmd.op = apsr_pkg::DP_MUL;
      apsr_pkg::ST_DIV1,
      apsr_pkg::ST_DIV2,
      apsr_pkg::ST_DIV3:      cmd.op = apsr_pkg::DP_DIV_STEP;
      apsr_pkg::ST_SET2:      cmd.op = apsr_pkg::DP_SET2;
      apsr_pkg::ST_SET3:      cmd.op = apsr_pkg::DP_SET3;
      apsr_pkg::ST_SNAP_INIT: cmd.op = apsr_pkg::DP_SNAP_INIT;
      apsr_pkg::ST_SNAP:      cmd.op = apsr_pkg::DP_SNAP_STEP;
      apsr_pkg::ST_PUB:       if (can_pub) cmd.op = apsr_pkg::DP_PUBLISH;
      default:                cmd.op = apsr_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= apsr_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else if (state == apsr_pkg::ST_DIV1 || state == apsr_pkg::ST_DIV2 ||
                   state == apsr_pkg::ST_DIV3 || state == apsr_pkg::ST_SNAP) begin
        cnt <= cnt + 6'd1;
      end
      if (cmd.op == apsr_pkg::DP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `APSR_ASSERT_IMP(a_pub_room, cmd.op == apsr_pkg::DP_PUBLISH, !out_valid || !out_stall)
  `APSR_ASSERT_NXT(a_pub_done, cmd.op == apsr_pkg::DP_PUBLISH,
                   out_valid && state == apsr_pkg::ST_IDLE)
  `APSR_ASSERT_NXT(a_accept_start, in_valid && !in_stall, state == apsr_pkg::ST_MUL)
  `APSR_ASSERT_IMP(a_snap_range, state == apsr_pkg::ST_SNAP, cnt < apsr_pkg::NumStd)

endmodule

>>> rtl/core/apsr_dp.sv
// datapath of the sample rate decoder: field capture, multiplier,
// shared restoring divider, serial snap search and result registers
// depends on apsr_pkg and the assertion macro header
`include "audio_pll_sample_rate_decode_core_assert.svh"

module apsr_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  apsr_pkg::cmd_t             cmd,
  input  logic                       regs_valid,
  input  logic [1:0]                 osc_sel,
  input  logic [4:0]                 pll_m,
  input  logic [9:0]                 pll_n,
  input  logic [2:0]                 pll_p,
  input  logic [7:0]                 out_ratio,
  input  logic [7:0]                 i2s_div,
  output logic [apsr_pkg::RawW-1:0]  raw_rate,
  output logic [apsr_pkg::RateW-1:0] snapped_rate,
  output logic [apsr_pkg::RateW-1:0] published_now,
  output logic                       rate_changed
);

  logic       v;
  logic [1:0] osc;
  logic [4:0] m;
  logic [9:0] n;
  logic [2:0] p;
  logic [7:0] ratio;
  logic [7:0] dv;

  logic [apsr_pkg::DivW-1:0]  quo;
  logic [apsr_pkg::RemW-1:0]  rem;
  logic [apsr_pkg::RemW-1:0]  dvsr;
  logic [apsr_pkg::RawW-1:0]  raw;
  logic [apsr_pkg::RateW-1:0] best;
  logic [apsr_pkg::RawW-1:0]  best_dist;
  logic [apsr_pkg::RateW-1:0] published;

  logic [4:0]                 m_eff;
  logic [11:0]                m_shift;
  logic [34:0]                prod;
  logic [apsr_pkg::RemW:0]    trial;
  logic                       qbit;
  logic [8:0]                 ratio2;
  logic [8:0]                 div2;
  logic [apsr_pkg::RemW-1:0]  div_den;
  logic [apsr_pkg::RateW-1:0] s;
  logic [apsr_pkg::RawW-1:0]  s_ext;
  logic [apsr_pkg::RawW-1:0]  cand_gap;

  assign m_eff   = (m == 5'd0) ? 5'd1 : m;
  assign m_shift = {7'd0, m_eff} << p;
  assign prod    = {10'd0, apsr_pkg::ref_freq(osc)} * {25'd0, n};
  assign trial   = {rem, quo[apsr_pkg::DivW-1]};
  assign qbit    = (trial >= {1'b0, dvsr});
  assign ratio2  = {1'b0, ratio} + 9'd2;
  assign div2    = {1'b0, dv} + 9'd2;
  // (div + 2) * 80
  assign div_den = {div2, 6'd0} + {2'd0, div2, 4'd0};
  assign s       = apsr_pkg::std_rate(cmd.snap_idx);
  assign s_ext   = {13'd0, s};
  assign cand_gap = (raw > s_ext) ? (raw - s_ext) : (s_ext - raw);

  always_ff @(posedge clk) begin
    case (cmd.op)
      apsr_pkg::DP_LOAD: begin
        v     <= regs_valid;
        osc   <= osc_sel;
        m     <= pll_m;
        n     <= pll_n;
        p     <= pll_p;
        ratio <= out_ratio;
        dv    <= i2s_div;
      end
      apsr_pkg::DP_MUL: begin
        quo  <= {3'd0, prod};
        rem  <= '0;
        dvsr <= {3'd0, m_shift};
      end
      apsr_pkg::DP_DIV_STEP: begin
        quo <= {quo[apsr_pkg::DivW-2:0], qbit};
        if (qbit) begin
          rem <= trial[apsr_pkg::RemW-1:0] - dvsr;
        end else begin
          rem <= trial[apsr_pkg::RemW-1:0];
        end
      end
      apsr_pkg::DP_SET2: begin
        // vco * 2 over (ratio + 2)
        quo  <= {quo[apsr_pkg::DivW-2:0], 1'b0};
        rem  <= '0;
        dvsr <= {6'd0, ratio2};
      end
      apsr_pkg::DP_SET3: begin
        // pout * 6 over (div + 2) * 80
        quo  <= {quo[apsr_pkg::DivW-3:0], 2'd0} + {quo[apsr_pkg::DivW-2:0], 1'b0};
        rem  <= '0;
        dvsr <= div_den;
      end
      apsr_pkg::DP_SNAP_INIT: begin
        raw       <= quo[apsr_pkg::RawW-1:0];
        best      <= '0;
        best_dist <= '1;
      end
      apsr_pkg::DP_SNAP_STEP: begin
        // strict compare keeps the lower rate on a tie
        if (cand_gap < best_dist) begin
          best_dist <= cand_gap;
          best      <= s;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == apsr_pkg::DP_PUBLISH) begin
      if (v) begin
        raw_rate      <= raw;
        snapped_rate  <= best;
        published_now <= best;
        rate_changed  <= (best != published);
      end else begin
        raw_rate      <= '0;
        snapped_rate  <= '0;
        published_now <= published;
        rate_changed  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      published <= '0;
    end else if (cmd.op == apsr_pkg::DP_PUBLISH && v) begin
      published <= best;
    end
  end

  `APSR_ASSERT_IMP(a_rem_bound, cmd.op == apsr_pkg::DP_DIV_STEP, rem < dvsr)
  `APSR_ASSERT_IMP(a_dvsr_nonzero, cmd.op == apsr_pkg::DP_DIV_STEP, dvsr != '0)
  `APSR_ASSERT_NXT(a_pub_only, cmd.op != apsr_pkg::DP_PUBLISH, $stable(published))

endmodule

>>> rtl/core/audio_pll_sample_rate_decode_core.sv
// top level of the audio pll sample rate decoder
// instantiates apsr_ctrl and apsr_dp, uses apsr_pkg
//
// One clock register snapshot in, one result out. A request is taken only
// while the block is idle, and the block stays busy through these steps in
// order: capture the fields, the ref*N multiply, three divisions of 38
// quotient bits each on a single restoring divider at one bit per cycle with
// a setup step before the second and the third, latching the raw rate, the
// search over the ten standard rates, and writing the output register. The
// result waits in that register, so a new request can start while the
// previous result is still stalled; publishing waits only while that
// register is still full and stalled.
module audio_pll_sample_rate_decode_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        regs_valid,
  input  logic [1:0]  osc_sel,
  input  logic [4:0]  pll_m,
  input  logic [9:0]  pll_n,
  input  logic [2:0]  pll_p,
  input  logic [7:0]  out_ratio,
  input  logic [7:0]  i2s_div,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [29:0] raw_rate,
  output logic [16:0] snapped_rate,
  output logic [16:0] published_now,
  output logic        rate_changed
);

  apsr_pkg::cmd_t cmd;

  apsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  apsr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .regs_valid    (regs_valid),
    .osc_sel       (osc_sel),
    .pll_m         (pll_m),
    .pll_n         (pll_n),
    .pll_p         (pll_p),
    .out_ratio     (out_ratio),
    .i2s_div       (i2s_div),
    .raw_rate      (raw_rate),
    .snapped_rate  (snapped_rate),
    .published_now (published_now),
    .rate_changed  (rate_changed)
  );

endmodule
